/* hw/rtl/htd_pkg.sv */
package htd_pkg;

	localparam int LEN_W  = 6;
	localparam int CODE_W = 32;
	localparam int DATA_W = 8;
	localparam int SYM_W  = 8;
	localparam int GRP    = 16;
	localparam int GRP_W  = 4;

	typedef struct packed {
		logic              is_data;
		logic [SYM_W-1:0]  idx;
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
		logic [DATA_W-1:0] data;
		logic              eos;
	} htd_item_t;

	typedef struct packed {
		logic             push;
		logic [SYM_W-1:0] sym;
		logic             status;
		logic             last;
	} htd_res_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_BIT   = 5'b00010,
		S_GRP   = 5'b00100,
		S_EMIT  = 5'b01000,
		S_FLUSH = 5'b10000
	} htd_state_t;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;
	localparam logic CMD_WRITE  = 1'b0;

	function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] len);
		logic [CODE_W-1:0] m;
		if (len >= LEN_W'(CODE_W)) begin
			m = '1;
		end else begin
			m = (CODE_W'(1) << len) - CODE_W'(1);
		end
		return m;
	endfunction

endpackage

/* hw/rtl/htd_front.sv */
module htd_front #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic [7:0]                  entry_index,
	input  logic [5:0]                  code_length,
	input  logic [31:0]                 code_bits,
	input  logic [7:0]                  data_byte,
	input  logic                        end_of_stream,
	output logic                        q_valid,
	output htd_pkg::htd_item_t          q_item,
	input  logic                        q_pop
);

	htd_pkg::htd_item_t mem_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               accept;
	logic               keep;
	htd_pkg::htd_item_t item;

	assign in_stall = (cnt_q == 2'd2);
	assign accept   = in_valid && !in_stall;
	// Writes to entries beyond the table are dropped here.
	assign keep     = (cmd != htd_pkg::CMD_WRITE) ||
		({1'b0, entry_index} < 9'(TABLE_ENTRIES));

	always_comb begin
		item.is_data = (cmd != htd_pkg::CMD_WRITE);
		item.idx     = entry_index;
		item.len     = code_length;
		item.code    = code_bits;
		item.data    = data_byte;
		item.eos     = end_of_stream;
	end

	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (accept && keep) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(accept && keep) - 2'(q_pop);
		end
	end

endmodule

/* hw/rtl/htd_table.sv */
module htd_table #(
	parameter int TABLE_ENTRIES = 256,
	parameter int MAX_CODE_LEN  = 32,
	parameter int IW            = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
	parameter int BW            = MAX_CODE_LEN + 1,
	parameter int CNTW          = $clog2(MAX_CODE_LEN + 2),
	parameter int NPAD          = ((TABLE_ENTRIES + 15) / 16) * 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [IW-1:0]               wr_idx,
	input  logic [htd_pkg::LEN_W-1:0]   wr_len,
	input  logic [htd_pkg::CODE_W-1:0]  wr_code,
	input  logic                        cmp_en,
	input  logic [BW-1:0]               buf_nx,
	input  logic [CNTW-1:0]             cnt_nx,
	output logic [NPAD-1:0]             match_s1
);

	localparam int CMPW = (BW > htd_pkg::CODE_W) ? BW : htd_pkg::CODE_W;

	logic [htd_pkg::LEN_W-1:0]  len_q  [TABLE_ENTRIES];
	logic [htd_pkg::CODE_W-1:0] code_q [TABLE_ENTRIES];
	logic [NPAD-1:0]            match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < TABLE_ENTRIES; e++) begin
				len_q[e] <= '0;
			end
		end else if (wr_en) begin
			len_q[wr_idx] <= wr_len;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			code_q[wr_idx] <= wr_code & htd_pkg::code_mask(wr_len);
		end
	end

	always_comb begin
		match = '0;
		for (int e = 0; e < TABLE_ENTRIES; e++) begin
			match[e] = (len_q[e] != '0) &&
				(len_q[e] <= htd_pkg::LEN_W'(MAX_CODE_LEN)) &&
				(len_q[e] == htd_pkg::LEN_W'(cnt_nx)) &&
				(CMPW'(code_q[e]) == CMPW'(buf_nx));
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			match_s1 <= match;
		end
	end

endmodule

/* hw/rtl/htd_back.sv */
module htd_back #(
	parameter int TABLE_ENTRIES = 256,
	parameter int MAX_CODE_LEN  = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  htd_pkg::htd_item_t         q_item,
	output logic                       q_pop,
	input  logic                       out_free,
	output htd_pkg::htd_res_t          res
);

	localparam int IW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int BW   = MAX_CODE_LEN + 1;
	localparam int CNTW = $clog2(MAX_CODE_LEN + 2);
	localparam int NPAD = ((TABLE_ENTRIES + 15) / 16) * 16;
	localparam int NG   = NPAD / 16;
	localparam int GW   = (NG > 1) ? $clog2(NG) : 1;

	htd_pkg::htd_state_t         state_q;
	logic [htd_pkg::DATA_W-1:0]  byte_q;
	logic                        eos_q;
	logic [2:0]                  bit_q;
	logic [BW-1:0]               buf_q;
	logic [CNTW-1:0]             cnt_q;
	logic [BW-1:0]               buf_nx;
	logic [CNTW-1:0]             cnt_nx;
	logic [NPAD-1:0]             match_s1;
	logic [NG-1:0]               grp_any;
	logic [htd_pkg::GRP_W-1:0]   grp_lo [NG];
	logic [NG-1:0]               grp_any_s2;
	logic [htd_pkg::GRP_W-1:0]   grp_lo_s2 [NG];
	logic                        pend_v_q;
	logic [htd_pkg::SYM_W-1:0]   pend_sym_q;
	logic                        pend_st_q;
	logic [GW-1:0]               sel_g;
	logic                        hit;
	logic                        ovf;
	logic [IW-1:0]               hit_idx;
	logic                        tbl_wr;
	logic                        emit_go;

	assign buf_nx = {buf_q[BW-2:0], byte_q[bit_q]};
	assign cnt_nx = cnt_q + CNTW'(1);
	assign q_pop  = (state_q == htd_pkg::S_IDLE) && q_valid;
	assign tbl_wr = q_pop && !q_item.is_data;

	htd_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tbl_wr),
		.wr_idx  (q_item.idx[IW-1:0]),
		.wr_len  (q_item.len),
		.wr_code (q_item.code),
		.cmp_en  (state_q == htd_pkg::S_BIT),
		.buf_nx  (buf_nx),
		.cnt_nx  (cnt_nx),
		.match_s1(match_s1)
	);

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_any[g] = |match_s1[g*16 +: 16];
			grp_lo[g]  = '0;
			for (int i = 15; i >= 0; i--) begin
				if (match_s1[g*16 + i]) begin
					grp_lo[g] = htd_pkg::GRP_W'(i);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == htd_pkg::S_GRP) begin
			grp_any_s2 <= grp_any;
			for (int g = 0; g < NG; g++) begin
				grp_lo_s2[g] <= grp_lo[g];
			end
		end
	end

	always_comb begin
		sel_g = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_any_s2[g]) begin
				sel_g = GW'(g);
			end
		end
		hit     = |grp_any_s2;
		hit_idx = IW'(int'(sel_g) * htd_pkg::GRP + int'(grp_lo_s2[sel_g]));
		ovf     = !hit && (cnt_q > CNTW'(MAX_CODE_LEN));
		emit_go = !((hit || ovf) && pend_v_q && !out_free);
	end

	always_comb begin
		res.push   = 1'b0;
		res.sym    = pend_sym_q;
		res.status = pend_st_q;
		res.last   = 1'b0;
		unique case (state_q)
			htd_pkg::S_EMIT: begin
				res.push = (hit || ovf) && pend_v_q && out_free;
			end
			htd_pkg::S_FLUSH: begin
				res.push = pend_v_q && out_free;
				res.last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_item.is_data) begin
			byte_q <= q_item.data;
			eos_q  <= q_item.eos;
		end
		if ((state_q == htd_pkg::S_EMIT) && emit_go && (hit || ovf)) begin
			pend_sym_q <= hit ? htd_pkg::SYM_W'(hit_idx) : '0;
			pend_st_q  <= hit ? htd_pkg::STATUS_OK : htd_pkg::STATUS_ERR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= htd_pkg::S_IDLE;
			bit_q    <= '0;
			buf_q    <= '0;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				htd_pkg::S_IDLE: begin
					if (q_pop && q_item.is_data) begin
						bit_q   <= 3'd7;
						state_q <= htd_pkg::S_BIT;
					end
				end
				htd_pkg::S_BIT: begin
					buf_q   <= buf_nx;
					cnt_q   <= cnt_nx;
					state_q <= htd_pkg::S_GRP;
				end
				htd_pkg::S_GRP: begin
					state_q <= htd_pkg::S_EMIT;
				end
				htd_pkg::S_EMIT: begin
					if (emit_go) begin
						if (hit || ovf) begin
							pend_v_q <= 1'b1;
						end
						if (hit || ovf || ((bit_q == 3'd0) && eos_q)) begin
							buf_q <= '0;
							cnt_q <= '0;
						end
						if (bit_q == 3'd0) begin
							state_q <= htd_pkg::S_FLUSH;
						end else begin
							bit_q   <= bit_q - 3'd1;
							state_q <= htd_pkg::S_BIT;
						end
					end
				end
				htd_pkg::S_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= htd_pkg::S_IDLE;
					end else if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= htd_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= htd_pkg::S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/huffman_table_decoder_top.sv */
// Huffman decoder against a loaded table of codewords, one per symbol.
// Input channel (in_valid/in_stall): a request with cmd 0 writes one table
// entry (entry_index, code_length, code_bits); cmd 1 delivers data_byte,
// decoded most significant bit first. end_of_stream drops leftover bits.
// Output channel (out_valid/out_stall): one result per decoded symbol or
// per error (status 1, symbol 0); last_of_run marks the final result of a
// data request. A table write gives no result.
// Requests go into a two-deep queue; the decode engine takes one at a time.
// A table write is done as the engine pops it. A data byte goes through
// three steps per bit (parallel table compare, group priority encode, emit)
// and then a flush step. A result is held until the next result or the
// flush, so its last_of_run can be set. While out_stall is high the
// engine waits at its next result and the queue fills, then in_stall
// rises. Reset empties the queue, the bit buffer and the result path,
// and marks all table entries unused.
module huffman_table_decoder_top #(
	parameter int TABLE_ENTRIES = 256,
	parameter int MAX_CODE_LEN  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [7:0]  entry_index,
	input  logic [5:0]  code_length,
	input  logic [31:0] code_bits,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  symbol,
	output logic        status,
	output logic        last_of_run
);

	logic               q_valid;
	logic               q_pop;
	htd_pkg::htd_item_t q_item;
	htd_pkg::htd_res_t  res;
	logic               out_free;
	logic               out_valid_q;
	logic [7:0]         symbol_q;
	logic               status_q;
	logic               last_q;

	htd_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.entry_index  (entry_index),
		.code_length  (code_length),
		.code_bits    (code_bits),
		.data_byte    (data_byte),
		.end_of_stream(end_of_stream),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop)
	);

	htd_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.out_free(out_free),
		.res     (res)
	);

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.push) begin
			symbol_q <= res.sym;
			status_q <= res.status;
			last_q   <= res.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign symbol      = symbol_q;
	assign status      = status_q;
	assign last_of_run = last_q;

endmodule

/* hw/rtl/htd_checker.sv */
module htd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] symbol,
	input logic       status,
	input logic       last_of_run
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Result was withdrawn while stalled.");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(symbol) && $stable(status) && $stable(last_of_run))
		else $error("Result changed while stalled.");

	a_err_sym: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> symbol == 8'd0)
		else $error("Error result carries a nonzero symbol.");

	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !out_valid)
		else $error("Result shown right after reset.");

endmodule

bind huffman_table_decoder_top htd_checker u_htd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.symbol     (symbol),
	.status     (status),
	.last_of_run(last_of_run)
);
